// ===== src/etisc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etisc_pkg: shared types and constants
// Op codes, register indexes, sequencer states and default values.
// ----------------------------------------------------------------------------
package etisc_pkg;

	localparam int AvgCountDef = 6;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	typedef enum logic [1:0] {
		OP_OVF   = 2'd0,
		OP_RCAP  = 2'd1,
		OP_LCAP  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_GAIN  = 3'd0,
		REG_SCALE = 3'd1,
		REG_MINSP = 3'd2,
		REG_DMIN  = 3'd3,
		REG_DMAX  = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_WSTART,
		ST_DIV,
		ST_INTEG,
		ST_MUL,
		ST_DRIVE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] capture_time;
		logic [14:0] desired_speed;
		logic signed [15:0] speed_offset;
	} in_beat_t;

	typedef struct packed {
		logic [9:0]  left_drive;
		logic [9:0]  right_drive;
		logic [31:0] left_measured;
		logic [31:0] right_measured;
		logic [31:0] left_edges;
		logic [31:0] right_edges;
	} out_beat_t;

endpackage

// ===== src/etisc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etisc_in_if / etisc_out_if: valid/ready channels
// One beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface etisc_in_if;
	logic valid;
	logic ready;
	etisc_pkg::in_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface etisc_out_if;
	logic valid;
	logic ready;
	etisc_pkg::out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/encoder_tach_integral_speed_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_tach_integral_speed_control: two-wheel encoder PI speed loop
// Period capture, averaging, and integral speed control on control ticks.
// ----------------------------------------------------------------------------
// Overflow beats finish in idle. Capture beats pass through an averaging
// state, where a group close of AVG_COUNT periods averages by one
// reciprocal multiply. Control ticks: per wheel a setup, a divide, an
// integrate, a multiply and a drive step (setup only if below min speed),
// then the output register loads once free; input ready returns after it.
// Reset (arst_n low) clears all wheel state and loads register defaults.
module encoder_tach_integral_speed_control #(
	parameter int AVG_COUNT = etisc_pkg::AvgCountDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [etisc_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [etisc_pkg::CfgDataW-1:0] cfg_data,
	etisc_in_if.sink   in_ch,
	etisc_out_if.source out_ch
);

	// reciprocal of AVG_COUNT: q = (x * AvgRecip) >> AvgShift, exact for 32-bit x
	localparam int AvgShift = 32 + $clog2(AVG_COUNT);
	localparam logic [32:0] AvgRecip =
		33'(((64'd1 << AvgShift) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));

	// configuration registers
	logic [15:0] gain_q;
	logic [31:0] scale_q;
	logic [14:0] minsp_q;
	logic [9:0]  dmin_q, dmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= 16'd256;
			scale_q <= 32'd384000000;
			minsp_q <= 15'd2560;
			dmin_q  <= 10'd80;
			dmax_q  <= 10'd720;
		end else if (cfg_we) begin
			case (cfg_idx)
				etisc_pkg::REG_GAIN:  gain_q  <= cfg_data[15:0];
				etisc_pkg::REG_SCALE: scale_q <= cfg_data;
				etisc_pkg::REG_MINSP: minsp_q <= cfg_data[14:0];
				etisc_pkg::REG_DMIN:  dmin_q  <= cfg_data[9:0];
				etisc_pkg::REG_DMAX:  dmax_q  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// per-wheel state, index 0 = left, 1 = right
	logic [31:0] accum_q [2];
	logic [31:0] psum_q [2];
	logic [2:0]  cnt_q [2];
	logic [31:0] pavg_q [2];
	logic signed [31:0] integ_q [2];
	logic [31:0] edges_q [2];

	etisc_pkg::state_t state_q, state_d;
	etisc_pkg::in_beat_t beat_q;
	logic wheel_q;                 // wheel being processed
	logic [5:0] step_q;            // divider / multiplier step count

	// serial units: restoring divider and shift-add multiplier (step count shared)
	logic [31:0] dvd_q;            // dividend / quotient
	logic [32:0] rem_q;            // remainder
	logic [31:0] dsr_q;            // divisor
	logic signed [49:0] prod_q;    // gain * acc product
	logic [15:0] mcand_q;
	logic signed [31:0] mplier_q;
	logic signed [17:0] target_q;
	logic [31:0] meas_q;
	logic signed [32:0] acc_w;
	logic [9:0] drv_d;
	logic [32:0] rem_sh;
	logic [33:0] rem_sub;
	logic signed [51:0] corr;
	logic [38:0] drv_raw;
	logic [66:0] avg_prod;

	// per-wheel results collected while the tick runs
	logic [9:0]  ldrv_q, rdrv_q;
	logic [31:0] lmeas_q, rmeas_q;

	etisc_pkg::out_beat_t obuf_q;
	logic ovalid_q;
	logic out_load;

	logic in_fire;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == etisc_pkg::ST_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = obuf_q;
	// output register takes a new result when empty or when the previous one is taken
	assign out_load = (state_q == etisc_pkg::ST_OUT) && (!ovalid_q || out_ch.ready);

	assign rem_sh  = {rem_q[31:0], dvd_q[31]};
	assign rem_sub = {1'b0, rem_sh} - {2'b0, dsr_q};

	// target of the current wheel
	logic signed [17:0] tgt_d;
	always_comb begin
		if (wheel_q)
			tgt_d = 18'(signed'({1'b0, beat_q.desired_speed})) + 18'(beat_q.speed_offset);
		else
			tgt_d = 18'(signed'({1'b0, beat_q.desired_speed})) - 18'(beat_q.speed_offset);
	end

	// saturating integrator add
	logic signed [33:0] acc_raw;
	always_comb begin
		acc_raw = 34'(integ_q[wheel_q]) + 34'(target_q) - 34'(signed'({1'b0, meas_q}));
		if (acc_raw > 34'sh07FFFFFFF)
			acc_w = 33'sh07FFFFFFF;
		else if (acc_raw < -34'sh080000000)
			acc_w = -33'sh080000000;
		else
			acc_w = acc_raw[32:0];
	end

	// drive from corrected value
	always_comb begin
		corr = 52'(target_q) * 52'sd256 + 52'(prod_q);
		drv_raw = corr[51:13];
		if (corr < 0)
			drv_d = dmin_q;
		else if (drv_raw < 39'(dmin_q))
			drv_d = dmin_q;
		else if (drv_raw > 39'(dmax_q))
			drv_d = dmax_q;
		else
			drv_d = drv_raw[9:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			etisc_pkg::ST_IDLE:
				if (in_fire) begin
					case (in_ch.data.op)
						etisc_pkg::OP_TICK: state_d = etisc_pkg::ST_WSTART;
						etisc_pkg::OP_OVF:  state_d = etisc_pkg::ST_IDLE;
						default:            state_d = etisc_pkg::ST_AVG;
					endcase
				end
			etisc_pkg::ST_AVG: state_d = etisc_pkg::ST_IDLE;
			etisc_pkg::ST_WSTART:
				if (tgt_d < 18'(signed'({1'b0, minsp_q})))
					state_d = wheel_q ? etisc_pkg::ST_OUT : etisc_pkg::ST_WSTART;
				else
					state_d = etisc_pkg::ST_DIV;
			etisc_pkg::ST_DIV:
				if (step_q == 6'd32) state_d = etisc_pkg::ST_INTEG;
			etisc_pkg::ST_INTEG: state_d = etisc_pkg::ST_MUL;
			etisc_pkg::ST_MUL:
				if (step_q == 6'd15) state_d = etisc_pkg::ST_DRIVE;
			etisc_pkg::ST_DRIVE:
				state_d = wheel_q ? etisc_pkg::ST_OUT : etisc_pkg::ST_WSTART;
			etisc_pkg::ST_OUT:
				if (out_load) state_d = etisc_pkg::ST_IDLE;
			default: state_d = etisc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= etisc_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// datapath
	logic        cwheel;
	assign cwheel = (beat_q.op == etisc_pkg::OP_RCAP);
	assign avg_prod = 67'(psum_q[cwheel]) * 67'(AvgRecip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < 2; w++) begin
				accum_q[w] <= '0;
				psum_q[w]  <= '0;
				cnt_q[w]   <= '0;
				pavg_q[w]  <= '0;
				integ_q[w] <= '0;
				edges_q[w] <= '0;
			end
			ovalid_q <= 1'b0;
			wheel_q  <= 1'b0;
			step_q   <= '0;
		end else begin
			if (out_load) begin
				obuf_q   <= {ldrv_q, rdrv_q, lmeas_q, rmeas_q, edges_q[0], edges_q[1]};
				ovalid_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready)
				ovalid_q <= 1'b0;
			case (state_q)
				etisc_pkg::ST_IDLE:
					if (in_fire) begin
						beat_q  <= in_ch.data;
						wheel_q <= 1'b0;
						step_q  <= '0;
						case (in_ch.data.op)
							etisc_pkg::OP_OVF: begin
								accum_q[0] <= accum_q[0] + 32'd65536;
								accum_q[1] <= accum_q[1] + 32'd65536;
							end
							etisc_pkg::OP_TICK: ;
							default: begin
								// close one period for the captured wheel
								logic w;
								w = (in_ch.data.op == etisc_pkg::OP_RCAP);
								accum_q[w] <= 32'd0 - 32'(in_ch.data.capture_time);
								edges_q[w] <= edges_q[w] + 32'd1;
								psum_q[w]  <= psum_q[w] + accum_q[w]
									+ 32'(in_ch.data.capture_time);
								cnt_q[w]   <= cnt_q[w] + 3'd1;
							end
						endcase
					end
				etisc_pkg::ST_AVG: begin
					// group close: period sum times the reciprocal of AVG_COUNT
					if (cnt_q[cwheel] >= 3'(AVG_COUNT)) begin
						pavg_q[cwheel] <= avg_prod[AvgShift +: 32];
						psum_q[cwheel] <= '0;
						cnt_q[cwheel]  <= '0;
					end
				end
				etisc_pkg::ST_WSTART: begin
					target_q <= tgt_d;
					dvd_q    <= scale_q;
					rem_q    <= '0;
					dsr_q    <= pavg_q[wheel_q];
					step_q   <= '0;
					if (tgt_d < 18'(signed'({1'b0, minsp_q}))) begin
						if (wheel_q) begin
							rdrv_q  <= '0;
							rmeas_q <= '0;
						end else begin
							ldrv_q  <= '0;
							lmeas_q <= '0;
						end
						wheel_q <= 1'b1;
					end
				end
				etisc_pkg::ST_DIV: begin
					if (!rem_sub[33]) begin
						rem_q <= rem_sub[32:0];
						dvd_q <= {dvd_q[30:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						dvd_q <= {dvd_q[30:0], 1'b0};
					end
					step_q <= step_q + 6'd1;
					if (step_q == 6'd32) begin
						// divide by zero gives all ones naturally
						meas_q <= dvd_q;
						step_q <= '0;
					end
				end
				etisc_pkg::ST_INTEG: begin
					integ_q[wheel_q] <= acc_w[31:0];
					mplier_q <= acc_w[31:0];
					mcand_q  <= gain_q;
					prod_q   <= '0;
					step_q   <= '0;
				end
				etisc_pkg::ST_MUL: begin
					// shift-add over the 16 gain bits, MSB first
					if (mcand_q[15])
						prod_q <= (prod_q <<< 1) + 50'(mplier_q);
					else
						prod_q <= prod_q <<< 1;
					mcand_q <= {mcand_q[14:0], 1'b0};
					step_q <= step_q + 6'd1;
				end
				etisc_pkg::ST_DRIVE: begin
					if (wheel_q) begin
						rdrv_q  <= drv_d;
						rmeas_q <= meas_q;
					end else begin
						ldrv_q  <= drv_d;
						lmeas_q <= meas_q;
					end
					wheel_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (state_q == etisc_pkg::ST_IDLE))
		else $error("ready outside idle");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> ($past(state_q) == etisc_pkg::ST_OUT))
		else $error("result without sequence");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == etisc_pkg::ST_IDLE)
			|-> (cnt_q[0] < 3'(AVG_COUNT) && cnt_q[1] < 3'(AVG_COUNT)))
		else $error("sample count overrun");
	a_drive_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == etisc_pkg::ST_DRIVE) |-> (step_q == 6'd16))
		else $error("multiply steps");
`endif

endmodule

// ===== verif/etisc_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etisc_chk: predictor and scoreboard for the encoder speed loop
// Mirrors wheel state and registers, predicts one result beat per control
// tick and compares each output beat field by field, oldest first.
// ----------------------------------------------------------------------------
module etisc_chk #(
	parameter int AVG_COUNT = etisc_pkg::AvgCountDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [etisc_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [etisc_pkg::CfgDataW-1:0] cfg_data,
	input  logic in_valid,
	input  logic in_ready,
	input  etisc_pkg::in_beat_t in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  etisc_pkg::out_beat_t out_data,
	output int errors,
	output int pending
);

	logic [15:0] gain;
	logic [31:0] scale;
	logic [14:0] min_sp;
	logic [9:0] dmin, dmax;
	logic [31:0] accum [2];
	logic [31:0] psum [2];
	logic [2:0] cnt [2];
	logic [31:0] avg [2];
	logic signed [31:0] integ [2];
	logic [31:0] edges [2];
	etisc_pkg::out_beat_t drive_q[$];

	task automatic capture(input int w, input logic [15:0] cap);
		logic [31:0] per;
		per = accum[w] + {16'd0, cap};
		accum[w] = 32'd0 - {16'd0, cap};
		edges[w] += 1;
		psum[w] += per;
		cnt[w] = cnt[w] + 3'd1;
		if (cnt[w] >= AVG_COUNT) begin
			avg[w] = psum[w] / AVG_COUNT;
			psum[w] = 0;
			cnt[w] = 0;
		end
	endtask

	task automatic wheel(input int w, input longint tgt, output logic [9:0] drv,
			output logic [31:0] meas);
		longint acc, corr, d;
		if (tgt < longint'(min_sp)) begin
			meas = 0;
			drv = 0;
			return;
		end
		meas = (avg[w] == 0) ? 32'hFFFF_FFFF : scale / avg[w];
		acc = longint'(integ[w]) + tgt - longint'({32'd0, meas});
		if (acc > 64'sd2147483647) acc = 64'sd2147483647;
		if (acc < -64'sd2147483648) acc = -64'sd2147483648;
		integ[w] = acc[31:0];
		corr = tgt * 256 + longint'({48'd0, gain}) * acc;
		if (corr < 0) begin
			drv = dmin;
			return;
		end
		d = corr >>> 13;
		if (d < longint'(dmin)) drv = dmin;
		else if (d > longint'(dmax)) drv = dmax;
		else drv = d[9:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		etisc_pkg::out_beat_t exp_b, got;
		longint des, off;
		int nerr;
		if (!arst_n) begin
			gain <= 16'd256;
			scale <= 32'd384000000;
			min_sp <= 15'd2560;
			dmin <= 10'd80;
			dmax <= 10'd720;
			for (int w = 0; w < 2; w++) begin
				accum[w] = 0; psum[w] = 0; cnt[w] = 0;
				avg[w] = 0; integ[w] = 0; edges[w] = 0;
			end
			drive_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			nerr = 0;
			if (cfg_we) begin
				case (etisc_pkg::reg_idx_t'(cfg_idx))
					etisc_pkg::REG_GAIN: gain <= cfg_data[15:0];
					etisc_pkg::REG_SCALE: scale <= cfg_data;
					etisc_pkg::REG_MINSP: min_sp <= cfg_data[14:0];
					etisc_pkg::REG_DMIN: dmin <= cfg_data[9:0];
					etisc_pkg::REG_DMAX: dmax <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (etisc_pkg::op_t'(in_data.op))
					etisc_pkg::OP_OVF: begin
						accum[0] += 32'd65536;
						accum[1] += 32'd65536;
					end
					etisc_pkg::OP_RCAP: capture(1, in_data.capture_time);
					etisc_pkg::OP_LCAP: capture(0, in_data.capture_time);
					etisc_pkg::OP_TICK: begin
						des = longint'({49'd0, in_data.desired_speed});
						off = longint'(in_data.speed_offset);
						wheel(0, des - off, exp_b.left_drive, exp_b.left_measured);
						wheel(1, des + off, exp_b.right_drive, exp_b.right_measured);
						exp_b.left_edges = edges[0];
						exp_b.right_edges = edges[1];
						drive_q.push_back(exp_b);
					end
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = out_data;
				if (drive_q.size() == 0) begin
					$error("unexpected result beat");
					nerr++;
				end else begin
					exp_b = drive_q.pop_front();
					if (got.left_drive !== exp_b.left_drive) begin
						$error("left_drive exp %0d got %0d", exp_b.left_drive, got.left_drive);
						nerr++;
					end
					if (got.right_drive !== exp_b.right_drive) begin
						$error("right_drive exp %0d got %0d", exp_b.right_drive,
							got.right_drive);
						nerr++;
					end
					if (got.left_measured !== exp_b.left_measured) begin
						$error("left_measured exp %0d got %0d", exp_b.left_measured,
							got.left_measured);
						nerr++;
					end
					if (got.right_measured !== exp_b.right_measured) begin
						$error("right_measured exp %0d got %0d", exp_b.right_measured,
							got.right_measured);
						nerr++;
					end
					if (got.left_edges !== exp_b.left_edges) begin
						$error("left_edges exp %0d got %0d", exp_b.left_edges,
							got.left_edges);
						nerr++;
					end
					if (got.right_edges !== exp_b.right_edges) begin
						$error("right_edges exp %0d got %0d", exp_b.right_edges,
							got.right_edges);
						nerr++;
					end
				end
			end
			errors <= errors + nerr;
			pending <= drive_q.size();
		end
	end

endmodule

// ===== verif/tb_encoder_tach_integral_speed_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_tach_integral_speed_control: stimulus and verdict
// Drives directed and random encoder beats under several register settings
// and idle patterns; the checker predicts and compares the result beats.
// ----------------------------------------------------------------------------
module tb_encoder_tach_integral_speed_control;

	localparam int WatchdogLimit = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [etisc_pkg::CfgIdxW-1:0] cfg_idx;
	logic [etisc_pkg::CfgDataW-1:0] cfg_data;
	int errors, pending;
	int src_idle_pct, snk_stall_pct;
	int quiet_cycles;
	bit timed_out;

	etisc_in_if in_ch ();
	etisc_out_if out_ch ();

	encoder_tach_integral_speed_control u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	etisc_chk u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_data(in_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_data(out_ch.data), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver side: random stall at the current percentage
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ch.ready <= 1'b0;
		else out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// watchdog: cycles without any accepted beat
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit && !timed_out) begin
			timed_out = 1;
			$display("** encoder_tach_integral_speed_control: FAILED **");
			$finish;
		end
	end

	// one beat: random source gap first, then hold valid until accepted;
	// valid stays up after the accept and is dropped by the next gap or drain
	task automatic send(input etisc_pkg::op_t op, input logic [15:0] cap,
			input logic [14:0] des, input logic signed [15:0] off);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{op: op, capture_time: cap, desired_speed: des,
			speed_offset: off};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(input etisc_pkg::reg_idx_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic tick(input int des, input int off);
		send(etisc_pkg::OP_TICK, 16'($urandom), 15'(des), 16'(off));
	endtask

	// mostly well-formed: a random mix of overflows, captures and in-range ticks
	task automatic random_beat();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			send(etisc_pkg::OP_OVF, 16'($urandom), 15'($urandom), 16'($urandom));
		else if (r < 45)
			send(etisc_pkg::OP_RCAP, 16'($urandom), 15'($urandom), 16'($urandom));
		else if (r < 70)
			send(etisc_pkg::OP_LCAP, 16'($urandom), 15'($urandom), 16'($urandom));
		else if (r < 95)
			tick($urandom_range(25600), int'($urandom_range(51200)) - 25600);
		else
			// raw field noise over the full width of each field
			send(etisc_pkg::OP_TICK, 16'($urandom), 15'($urandom), 16'($urandom));
	endtask

	initial begin
		timed_out = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero average saturates measured speed
		tick(12800, 0);
		tick(25600, -25600);
		tick(0, 25600);
		tick(32767, -32768);
		// fill both averages with extreme captures and overflows
		for (int i = 0; i < 6; i++) begin
			send(etisc_pkg::OP_OVF, 16'h0, 15'h0, 16'h0);
			send(etisc_pkg::OP_RCAP, 16'hFFFF, 15'h7FFF, 16'h7FFF);
			send(etisc_pkg::OP_LCAP, 16'h0000, 15'h0, 16'h8000);
		end
		tick(2559, 0);
		tick(2560, 0);
		tick(25600, 1000);
		drain();

		// register sweep with extremes; drive_min above drive_max included
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1, 5: begin src_idle_pct = 80; snk_stall_pct = 0; end
				2, 6: begin src_idle_pct = 0; snk_stall_pct = 80; end
				default: begin src_idle_pct = 10; snk_stall_pct = 10; end
			endcase
			case (phase)
				0: begin
					write_reg(etisc_pkg::REG_GAIN, 32'd0);
					write_reg(etisc_pkg::REG_SCALE, 32'd1);
					write_reg(etisc_pkg::REG_MINSP, 32'd0);
					write_reg(etisc_pkg::REG_DMIN, 32'd0);
					write_reg(etisc_pkg::REG_DMAX, 32'd1023);
				end
				1: begin
					write_reg(etisc_pkg::REG_GAIN, 32'd65535);
					write_reg(etisc_pkg::REG_SCALE, 32'hFFFF_FFFF);
					write_reg(etisc_pkg::REG_MINSP, 32'd25600);
					write_reg(etisc_pkg::REG_DMIN, 32'd1023);
					write_reg(etisc_pkg::REG_DMAX, 32'd0);
				end
				2: begin
					write_reg(etisc_pkg::REG_GAIN, 32'd256);
					write_reg(etisc_pkg::REG_SCALE, 32'd384000000);
					write_reg(etisc_pkg::REG_MINSP, 32'd2560);
					write_reg(etisc_pkg::REG_DMIN, 32'd80);
					write_reg(etisc_pkg::REG_DMAX, 32'd720);
				end
				default: begin
					write_reg(etisc_pkg::REG_GAIN, $urandom_range(65535));
					write_reg(etisc_pkg::REG_SCALE, $urandom | 32'd1);
					write_reg(etisc_pkg::REG_MINSP, $urandom_range(25600));
					write_reg(etisc_pkg::REG_DMIN, $urandom_range(1023));
					write_reg(etisc_pkg::REG_DMAX, $urandom_range(1023));
					// unused index must be ignored
					write_reg(etisc_pkg::reg_idx_t'(3'd7), $urandom);
				end
			endcase
			for (int i = 0; i < 135; i++) random_beat();
			drain();
		end

		if (errors == 0)
			$display("** encoder_tach_integral_speed_control: PASSED **");
		else
			$display("** encoder_tach_integral_speed_control: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
src/etisc_pkg.sv
src/etisc_if.sv
src/encoder_tach_integral_speed_control.sv
verif/etisc_chk.sv
verif/tb_encoder_tach_integral_speed_control.sv
